FILE: rtl/mips_subset_execute_unit_top_macros.svh
// Assertion helpers used by the checker file.
`ifndef MIPS_SUBSET_EXECUTE_UNIT_TOP_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSEU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mseu_pkg.sv
package mseu_pkg;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 32;
    localparam int RF_AW     = 5;
    localparam int CFG_W     = 11;

    localparam logic [CFG_W-1:0] PLEN_RESET = 11'd8;

    typedef logic [5:0] t_opcode;
    typedef logic [5:0] t_funct;

    localparam t_opcode OP_RTYPE = 6'd0;
    localparam t_opcode OP_J     = 6'd2;
    localparam t_opcode OP_BEQ   = 6'd4;
    localparam t_opcode OP_BNE   = 6'd5;
    localparam t_opcode OP_ADDI  = 6'd8;
    localparam t_opcode OP_SLTI  = 6'd10;
    localparam t_opcode OP_LW    = 6'd35;
    localparam t_opcode OP_SW    = 6'd43;

    localparam t_funct FN_ADD = 6'd32;
    localparam t_funct FN_SUB = 6'd34;
    localparam t_funct FN_AND = 6'd36;
    localparam t_funct FN_OR  = 6'd37;
    localparam t_funct FN_XOR = 6'd38;
    localparam t_funct FN_SLT = 6'd42;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNSUP = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    function automatic logic lt_signed(input logic [XLEN-1:0] a, input logic [XLEN-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

FILE: rtl/mips_subset_execute_unit_top.sv
// Each accepted request passes through S1, S2 and the output register to its result.
// Throughput: one instruction per cycle while o_stall is low; the limit is the
// register file read plus the operand forward and ALU path in the execute stage.
// Reset (i_rst_n low, synchronous): pipeline emptied, PC = 0, program length = 8,
// register file valid bits cleared; then a pass zeroes the data memory, with
// o_stall held high until it finishes.
module mips_subset_execute_unit_top #(
    parameter int DATA_WORDS = 128,
    parameter int PC_BITS    = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration: program length
    input  logic                                 i_cfg_wr_en,
    input  logic [mseu_pkg::CFG_W-1:0]           i_cfg_wr_data,
    // request channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [mseu_pkg::XLEN-1:0]            i_instruction,
    // result channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [PC_BITS-1:0]                   o_next_pc,
    output logic                                 o_done_res,
    output logic                                 o_reg_write,
    output logic [mseu_pkg::RF_AW-1:0]           o_reg_index,
    output logic [mseu_pkg::XLEN-1:0]            o_reg_value,
    output logic                                 o_mem_write,
    output logic [$clog2(DATA_WORDS)-1:0]        o_mem_index,
    output logic [mseu_pkg::XLEN-1:0]            o_mem_value,
    output logic [1:0]                           o_status
);
    import mseu_pkg::*;

    localparam int DM_AW = $clog2(DATA_WORDS);
    localparam int CMP_W = (PC_BITS > CFG_W) ? PC_BITS : CFG_W;
    localparam logic [XLEN-1:0]  DM_LIMIT = XLEN'(DATA_WORDS);
    localparam logic [DM_AW-1:0] CLR_LAST = DM_AW'(DATA_WORDS - 1);

    // ------------------------------------------------------------------
    // Pipeline:
    //   accept edge : register file read at rs/rt, instruction into S1
    //   S1 (execute): forward operands, ALU, branch, address; data memory
    //                 read/write issued on the S1 -> S2 edge
    //   S2 (memory) : load data available; register file write committed
    //                 on the S2 -> output edge
    //   output reg  : result held for the downstream side
    // ------------------------------------------------------------------

    // configuration and architectural PC
    logic [CFG_W-1:0]   r_plen;
    logic [PC_BITS-1:0] r_pc;

    // data memory clearing pass
    logic               r_clr_busy;
    logic [DM_AW-1:0]   r_clr_idx;

    // register file and its read capture
    logic [XLEN-1:0]      rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    logic [XLEN-1:0]      r_rd_a;
    logic [XLEN-1:0]      r_rd_b;
    logic                 r_a_vld;
    logic                 r_b_vld;
    logic                 r_a_hit;
    logic                 r_b_hit;
    logic [XLEN-1:0]      r_hit_val;

    // S1
    logic               r_s1_vld;
    logic [XLEN-1:0]    r_s1_ins;

    // S2
    logic               r_s2_vld;
    logic [PC_BITS-1:0] r_s2_next;
    logic               r_s2_done;
    logic               r_s2_wr;
    logic [RF_AW-1:0]   r_s2_widx;
    logic [XLEN-1:0]    r_s2_wval;
    logic               r_s2_ld;
    logic               r_s2_ldm;
    logic               r_s2_mw;
    logic [DM_AW-1:0]   r_s2_midx;
    logic [XLEN-1:0]    r_s2_mval;
    t_status            r_s2_status;

    // data memory
    logic [XLEN-1:0]    dm_mem [DATA_WORDS];
    logic [XLEN-1:0]    r_dm_q;

    // output register
    logic               r_o_vld;
    logic [PC_BITS-1:0] r_o_next;
    logic               r_o_done;
    logic               r_o_wr;
    logic [RF_AW-1:0]   r_o_widx;
    logic [XLEN-1:0]    r_o_wval;
    logic               r_o_mw;
    logic [DM_AW-1:0]   r_o_midx;
    logic [XLEN-1:0]    r_o_mval;
    t_status            r_o_status;

    // ------------------------------------------------------------------
    // Flow control: each stage advances when the one ahead is empty or
    // advancing itself.
    // ------------------------------------------------------------------
    logic out_free, s2_mv, s2_free, s1_mv, s1_free, accept;

    assign out_free = !r_o_vld || !i_stall;
    assign s2_mv    = r_s2_vld && out_free;
    assign s2_free  = !r_s2_vld || out_free;
    assign s1_mv    = r_s1_vld && s2_free;
    assign s1_free  = !r_s1_vld || s2_free;
    assign o_stall  = r_clr_busy || !s1_free;
    assign accept   = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Register file commit from S2 (load data comes straight from the
    // data memory read register).
    // ------------------------------------------------------------------
    logic [XLEN-1:0] s2_wdata;
    logic            rf_we;
    logic [RF_AW-1:0] in_rs, in_rt;

    assign s2_wdata = r_s2_ld ? r_dm_q : r_s2_wval;
    assign rf_we    = s2_mv && r_s2_wr;
    assign in_rs    = i_instruction[25:21];
    assign in_rt    = i_instruction[20:16];

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf_mem[r_s2_widx] <= s2_wdata;
        end
        if (accept) begin
            r_rd_a    <= rf_mem[in_rs];
            r_rd_b    <= rf_mem[in_rt];
            r_a_vld   <= r_rf_vld[in_rs];
            r_b_vld   <= r_rf_vld[in_rt];
            // write-first: a commit on the same edge overrides the stale read
            r_a_hit   <= rf_we && (r_s2_widx == in_rs);
            r_b_hit   <= rf_we && (r_s2_widx == in_rt);
            r_hit_val <= s2_wdata;
        end
    end

    // An entry never written since reset reads as zero; $0 is never written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (rf_we) begin
            r_rf_vld[r_s2_widx] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // S1: operand forwarding and execute
    // ------------------------------------------------------------------
    t_opcode          s1_op;
    t_funct           s1_fn;
    logic [RF_AW-1:0] s1_rs, s1_rt, s1_rd;
    logic [XLEN-1:0]  s1_simm;
    logic [XLEN-1:0]  rf_a, rf_b, op_a, op_b;
    logic [XLEN-1:0]  sum_ai, sum_ab, dif_ab;
    logic [PC_BITS-1:0] pc_inc, br_tgt;
    logic             addr_ok;

    assign s1_op   = r_s1_ins[31:26];
    assign s1_rs   = r_s1_ins[25:21];
    assign s1_rt   = r_s1_ins[20:16];
    assign s1_rd   = r_s1_ins[15:11];
    assign s1_fn   = r_s1_ins[5:0];
    assign s1_simm = {{(XLEN-16){r_s1_ins[15]}}, r_s1_ins[15:0]};

    assign rf_a = r_a_hit ? r_hit_val : (r_a_vld ? r_rd_a : '0);
    assign rf_b = r_b_hit ? r_hit_val : (r_b_vld ? r_rd_b : '0);

    // S2 holds the immediately older instruction whose write is still pending
    assign op_a = (r_s2_vld && r_s2_wr && (r_s2_widx == s1_rs)) ? s2_wdata : rf_a;
    assign op_b = (r_s2_vld && r_s2_wr && (r_s2_widx == s1_rt)) ? s2_wdata : rf_b;

    assign sum_ai  = op_a + s1_simm;
    assign sum_ab  = op_a + op_b;
    assign dif_ab  = op_a - op_b;
    assign pc_inc  = r_pc + PC_BITS'(1);
    assign br_tgt  = pc_inc + s1_simm[PC_BITS-1:0];
    assign addr_ok = sum_ai < DM_LIMIT;

    logic [PC_BITS-1:0] s1_next;
    logic               s1_wr;
    logic [RF_AW-1:0]   s1_widx;
    logic [XLEN-1:0]    s1_wval;
    logic               s1_ld;
    logic               s1_rd_dm;
    logic               s1_mw;
    logic [DM_AW-1:0]   s1_midx;
    logic [XLEN-1:0]    s1_mval;
    t_status            s1_status;
    logic               s1_done;

    always_comb begin
        s1_next   = pc_inc;
        s1_wr     = 1'b0;
        s1_widx   = '0;
        s1_wval   = '0;
        s1_ld     = 1'b0;
        s1_rd_dm  = 1'b0;
        s1_mw     = 1'b0;
        s1_midx   = '0;
        s1_mval   = '0;
        s1_status = ST_OK;

        unique case (s1_op) inside
            OP_RTYPE: begin
                s1_wr   = 1'b1;
                s1_widx = s1_rd;
                unique case (s1_fn)
                    FN_ADD:  s1_wval = sum_ab;
                    FN_SUB:  s1_wval = dif_ab;
                    FN_AND:  s1_wval = op_a & op_b;
                    FN_OR:   s1_wval = op_a | op_b;
                    FN_XOR:  s1_wval = op_a ^ op_b;
                    FN_SLT:  s1_wval = {{(XLEN-1){1'b0}}, lt_signed(op_a, op_b)};
                    default: begin
                        s1_wr     = 1'b0;
                        s1_status = ST_UNSUP;
                    end
                endcase
            end
            OP_J: begin
                s1_next = r_s1_ins[PC_BITS-1:0];
            end
            OP_BEQ, OP_BNE: begin
                if ((op_a == op_b) == (s1_op == OP_BEQ)) begin
                    s1_next = br_tgt;
                end
            end
            OP_ADDI: begin
                s1_wr   = 1'b1;
                s1_widx = s1_rt;
                s1_wval = sum_ai;
            end
            OP_SLTI: begin
                s1_wr   = 1'b1;
                s1_widx = s1_rt;
                s1_wval = {{(XLEN-1){1'b0}}, lt_signed(op_a, s1_simm)};
            end
            OP_LW, OP_SW: begin
                s1_midx = sum_ai[DM_AW-1:0];
                if (!addr_ok) begin
                    s1_status = ST_RANGE;
                end else if (s1_op == OP_LW) begin
                    s1_rd_dm = 1'b1;
                    s1_ld    = 1'b1;
                    s1_wr    = 1'b1;
                    s1_widx  = s1_rt;
                end else begin
                    s1_mw   = 1'b1;
                    s1_mval = op_b;
                end
            end
            default: begin
                s1_status = ST_UNSUP;
            end
        endcase

        // drop writes aimed at $0 and report them as no write
        if (!s1_wr || (s1_widx == '0)) begin
            s1_wr   = 1'b0;
            s1_ld   = 1'b0;
            s1_widx = '0;
            s1_wval = '0;
        end
    end

    assign s1_done = CMP_W'(s1_next) >= CMP_W'(r_plen);

    // ------------------------------------------------------------------
    // Data memory: store on the S1 -> S2 edge, load read registered into S2.
    // The clearing pass owns the write port while it runs; no request is
    // in flight then.
    // ------------------------------------------------------------------
    logic             dm_we;
    logic [DM_AW-1:0] dm_waddr;
    logic [XLEN-1:0]  dm_wdata;

    assign dm_we    = r_clr_busy || (s1_mv && s1_mw);
    assign dm_waddr = r_clr_busy ? r_clr_idx : s1_midx;
    assign dm_wdata = r_clr_busy ? '0 : s1_mval;

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            dm_mem[dm_waddr] <= dm_wdata;
        end
        if (s1_mv && s1_rd_dm) begin
            r_dm_q <= dm_mem[s1_midx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + DM_AW'(1);
            if (r_clr_idx == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen   <= PLEN_RESET;
            r_pc     <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_plen <= i_cfg_wr_data;
            end
            // advance the PC as each instruction leaves execute
            if (s1_mv) begin
                r_pc <= s1_next;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_mv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_mv) begin
                r_s2_vld <= 1'b1;
            end else if (s2_mv) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_mv) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ins <= i_instruction;
        end
        if (s1_mv) begin
            r_s2_next   <= s1_next;
            r_s2_done   <= s1_done;
            r_s2_wr     <= s1_wr;
            r_s2_widx   <= s1_widx;
            r_s2_wval   <= s1_wval;
            r_s2_ld     <= s1_ld;
            r_s2_ldm    <= s1_rd_dm;
            r_s2_mw     <= s1_mw;
            r_s2_midx   <= s1_midx;
            r_s2_mval   <= s1_mval;
            r_s2_status <= s1_status;
        end
        if (s2_mv) begin
            r_o_next   <= r_s2_next;
            r_o_done   <= r_s2_done;
            r_o_wr     <= r_s2_wr;
            r_o_widx   <= r_s2_widx;
            r_o_wval   <= s2_wdata;
            r_o_mw     <= r_s2_mw;
            r_o_midx   <= r_s2_midx;
            // a load reports the word it read, even when aimed at $0
            r_o_mval   <= r_s2_ldm ? r_dm_q : r_s2_mval;
            r_o_status <= r_s2_status;
        end
    end

    assign o_valid     = r_o_vld;
    assign o_next_pc   = r_o_next;
    assign o_done_res  = r_o_done;
    assign o_reg_write = r_o_wr;
    assign o_reg_index = r_o_widx;
    assign o_reg_value = r_o_wval;
    assign o_mem_write = r_o_mw;
    assign o_mem_index = r_o_midx;
    assign o_mem_value = r_o_mval;
    assign o_status    = r_o_status;

endmodule

FILE: rtl/mseu_checker.sv
`include "mips_subset_execute_unit_top_macros.svh"

module mseu_checker #(
    parameter int PC_BITS = 10
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_stall,
    input logic                       o_valid,
    input logic [PC_BITS-1:0]         o_next_pc,
    input logic                       o_reg_write,
    input logic [mseu_pkg::RF_AW-1:0] o_reg_index,
    input logic [mseu_pkg::XLEN-1:0]  o_reg_value,
    input logic                       o_mem_write,
    input logic [1:0]                 o_status
);
    import mseu_pkg::*;

    `MSEU_ASSERT_SAME(a_no_reg0_write, i_clk, i_rst_n, o_valid && o_reg_write, o_reg_index != '0, "register write reported for register zero")

    `MSEU_ASSERT_SAME(a_store_excl, i_clk, i_rst_n, o_valid && o_mem_write, !o_reg_write && (o_status == ST_OK), "store reported with register write or bad status")

    `MSEU_ASSERT_SAME(a_fault_no_write, i_clk, i_rst_n, o_valid && (o_status != ST_OK), !o_reg_write && !o_mem_write, "faulting request reported a write")

    `MSEU_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_next_pc) && $stable(o_reg_value), "stalled result changed")

endmodule

bind mips_subset_execute_unit_top mseu_checker #(.PC_BITS(PC_BITS)) u_mseu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_stall     (i_stall),
    .o_valid     (o_valid),
    .o_next_pc   (o_next_pc),
    .o_reg_write (o_reg_write),
    .o_reg_index (o_reg_index),
    .o_reg_value (o_reg_value),
    .o_mem_write (o_mem_write),
    .o_status    (o_status)
);
